// File: hdl/nir_pkg.sv
// ----------------------------------------------------------------------------
// nir_pkg: shared types and constants for the NEC infrared pulse decoder
// Request and result words, phase codes, register map and the key table.
// ----------------------------------------------------------------------------
`default_nettype none

package nir_pkg;

    localparam int TIME_W     = 16;
    localparam int PHASE_W    = 3;
    localparam int CODE_W     = 32;
    localparam int KEY_IDX_W  = 5;
    localparam int KEY_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_COUNT  = 8;
    localparam int KEY_TABLE_LEN = 21;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEADER_MARK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEADER_SPACE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_MARK     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_SPACE    = 3'd4;

    // Request kinds
    localparam logic REQ_EDGE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SPACE_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD    = 3'd7;

    // Register reset values (microseconds)
    localparam logic [TIME_W-1:0] RST_LEADER_MARK_MIN  = 16'd8500;
    localparam logic [TIME_W-1:0] RST_LEADER_MARK_MAX  = 16'd9500;
    localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
    localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MAX = 16'd5000;
    localparam logic [TIME_W-1:0] RST_PULSE_MIN        = 16'd400;
    localparam logic [TIME_W-1:0] RST_BIT_MARK_MAX     = 16'd700;
    localparam logic [TIME_W-1:0] RST_BIT_SPACE_MAX    = 16'd1800;
    localparam logic [TIME_W-1:0] RST_ONE_THRESHOLD    = 16'd1000;

    localparam logic [KEY_W-1:0] KEY_TABLE [KEY_TABLE_LEN] = '{
        8'ha2, 8'h62, 8'he2, 8'h22, 8'h02, 8'hc2, 8'he0, 8'ha8, 8'h90, 8'h68, 8'h98,
        8'hb0, 8'h30, 8'h18, 8'h7a, 8'h10, 8'h38, 8'h5a, 8'h42, 8'h4a, 8'h52
    };

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] elapsed_us;
    } req_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic                 expect_rising;
        logic                 frame_error;
        logic                 code_valid;
        logic [CODE_W-1:0]    code;
        logic                 key_found;
        logic [KEY_IDX_W-1:0] key_index;
    } rsp_t;

    typedef struct packed {
        logic                 found;
        logic [KEY_IDX_W-1:0] index;
    } key_match_t;

endpackage

`default_nettype wire

// File: hdl/nir_key_lookup.sv
// ----------------------------------------------------------------------------
// nir_key_lookup: key table match
// Compares a command byte with the key table; the highest matching entry wins.
// ----------------------------------------------------------------------------
`default_nettype none

module nir_key_lookup #(
    parameter int KEY_COUNT = 21
) (
    input  wire logic [nir_pkg::KEY_W-1:0] key,
    output nir_pkg::key_match_t            match
);
    import nir_pkg::*;

    localparam int SCAN = (KEY_COUNT < KEY_TABLE_LEN) ? KEY_COUNT : KEY_TABLE_LEN;

    always_comb
    begin
        match = '0;
        // later entries override earlier ones
        for (int i = 0; i < SCAN; i++)
        begin
            if (KEY_TABLE[i] == key)
            begin
                match.found = 1'b1;
                match.index = KEY_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/nec_ir_pulse_decoder_unit.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_unit: NEC infrared remote frame decoder
// Times leader and bit pulses, shifts in the code and looks up the key.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): one word per IR edge, carrying
//   the microseconds since the previous edge, or a timer timeout word.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one result word per
//   request word, in order: phase after the word, edge polarity, error, and
//   on the last bit of a frame the 32-bit code with its key table match.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): timing window
//   registers, always ready; write them only while the decoder is idle.
// Timing:
//   One word per cycle sustained while rsp_stall is low. A request word is held
//   in the input register; the window compares, shift and key match run in a
//   single pass from it into the result register, where the result is offered.
//   When rsp_stall holds the result register, the input register still takes
//   one more word, then req_stall rises until the result is taken.
// Reset:
//   rst_n clears the valid bits of both pipeline registers, puts the decoder
//   in idle and loads the default NEC timing windows.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_pulse_decoder_unit #(
    parameter int CODE_BITS = 32,
    parameter int KEY_COUNT = 21
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          req_valid,
    output      logic                          req_stall,
    input  wire nir_pkg::req_t                 req,

    output      logic                          rsp_valid,
    input  wire logic                          rsp_stall,
    output      nir_pkg::rsp_t                 rsp,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nir_pkg::TIME_W-1:0]    cfg_data
);
    import nir_pkg::*;

    localparam int CNT_W = $clog2(CODE_BITS + 1);

    // Configuration registers
    logic [TIME_W-1:0] lm_min_reg, lm_max_reg, ls_min_reg, ls_max_reg;
    logic [TIME_W-1:0] pulse_min_reg, mark_max_reg, space_max_reg, one_thr_reg;

    // Pipeline registers
    logic  in_valid_reg;
    req_t  in_item_reg;
    logic  out_valid_reg;
    rsp_t  out_item_reg;
    rsp_t  out_item_next;

    // Decoder state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_inc;
    logic [CODE_W-1:0]  shift_reg, shift_next, shift_in;

    logic       out_open;
    logic       advance;
    logic [TIME_W-1:0] t;
    logic       err;
    logic       done;
    logic       one_bit;
    key_match_t match;

    assign cfg_ready = 1'b1;

    assign out_open  = !out_valid_reg || !rsp_stall;
    assign advance   = in_valid_reg && out_open;
    assign req_stall = in_valid_reg && !out_open;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    assign t        = in_item_reg.elapsed_us;
    assign one_bit  = (t > one_thr_reg);
    assign shift_in = {shift_reg[CODE_W-2:0], one_bit};
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign done     = (cnt_inc >= CNT_W'(CODE_BITS));

    nir_key_lookup #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_lookup (
        .key   (shift_in[15:8]),
        .match (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lm_min_reg    <= RST_LEADER_MARK_MIN;
            lm_max_reg    <= RST_LEADER_MARK_MAX;
            ls_min_reg    <= RST_LEADER_SPACE_MIN;
            ls_max_reg    <= RST_LEADER_SPACE_MAX;
            pulse_min_reg <= RST_PULSE_MIN;
            mark_max_reg  <= RST_BIT_MARK_MAX;
            space_max_reg <= RST_BIT_SPACE_MAX;
            one_thr_reg   <= RST_ONE_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEADER_MARK_MIN:  lm_min_reg    <= cfg_data;
                REG_LEADER_MARK_MAX:  lm_max_reg    <= cfg_data;
                REG_LEADER_SPACE_MIN: ls_min_reg    <= cfg_data;
                REG_LEADER_SPACE_MAX: ls_max_reg    <= cfg_data;
                REG_PULSE_MIN:        pulse_min_reg <= cfg_data;
                REG_BIT_MARK_MAX:     mark_max_reg  <= cfg_data;
                REG_BIT_SPACE_MAX:    space_max_reg <= cfg_data;
                REG_ONE_THRESHOLD:    one_thr_reg   <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        err        = 1'b0;
        out_item_next = '0;

        if (in_item_reg.req_type == REQ_TIMEOUT)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEADER_MARK:
                begin
                    if (t > lm_min_reg && t < lm_max_reg)
                        phase_next = PH_LEADER_SPACE;
                    else
                        err = 1'b1;
                end
                PH_LEADER_SPACE:
                begin
                    if (t > ls_min_reg && t < ls_max_reg)
                        phase_next = PH_BIT_MARK;
                    else
                        err = 1'b1;
                end
                PH_BIT_MARK:
                begin
                    if (t > pulse_min_reg && t < mark_max_reg)
                        phase_next = PH_BIT_SPACE;
                    else
                        err = 1'b1;
                end
                PH_BIT_SPACE:
                begin
                    if (t > pulse_min_reg && t < space_max_reg)
                    begin
                        shift_next = shift_in;
                        cnt_next   = cnt_inc;
                        if (done)
                        begin
                            phase_next               = PH_IDLE;
                            out_item_next.code_valid = 1'b1;
                            out_item_next.code       = shift_in;
                            out_item_next.key_found  = match.found;
                            out_item_next.key_index  = match.index;
                        end
                        else
                        begin
                            phase_next = PH_BIT_MARK;
                        end
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                default:
                begin
                    // start of frame: time since the last edge means nothing
                    cnt_next   = '0;
                    shift_next = '0;
                    phase_next = PH_LEADER_MARK;
                end
            endcase
            if (err)
                phase_next = PH_IDLE;
        end

        out_item_next.phase         = phase_next;
        out_item_next.expect_rising = (phase_next == PH_LEADER_MARK) ||
                                      (phase_next == PH_BIT_MARK);
        out_item_next.frame_error   = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            if (!in_valid_reg || advance)
                in_valid_reg <= req_valid;
            if (out_open)
                out_valid_reg <= in_valid_reg;
            if (advance)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                shift_reg <= shift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_valid_reg || advance)
            in_item_reg <= req;
        if (advance)
            out_item_reg <= out_item_next;
    end

    // A finished frame always leaves the decoder idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.code_valid |-> rsp.phase == PH_IDLE)
        else $error("code reported without returning to idle");

    // A word cannot both complete a frame and abort it
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.code_valid && rsp.frame_error))
        else $error("frame error and code valid together");

    // Code and key fields are clear unless a frame completed
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.code_valid |-> rsp.code == '0 && !rsp.key_found)
        else $error("code fields set without a complete frame");

    // Phase register only ever holds a defined phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE || phase_reg == PH_LEADER_MARK ||
        phase_reg == PH_LEADER_SPACE || phase_reg == PH_BIT_MARK ||
        phase_reg == PH_BIT_SPACE)
        else $error("phase register out of range");

    // A timeout word always drops the decoder to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.req_type == REQ_TIMEOUT |=> phase_reg == PH_IDLE)
        else $error("timeout did not return to idle");

endmodule

`default_nettype wire

// File: bench/nec_ir_frame_checker.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_checker: result predictor and scoreboard for the NEC IR decoder
// Watches the request, result and register channels, decodes every accepted
// request word with its own copy of the timing windows and frame state, and
// compares each accepted result word field by field with the oldest decode.
// ----------------------------------------------------------------------------
module nec_ir_frame_checker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    input  logic                          req_stall,
    input  nir_pkg::req_t                 req,

    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  nir_pkg::rsp_t                 rsp,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nir_pkg::TIME_W-1:0]    cfg_data,

    output int                            pending,
    output int                            failures
);

    timeunit 1ns;
    timeprecision 1ps;

    import nir_pkg::*;

    logic [TIME_W-1:0]  win [CFG_COUNT];
    logic [PHASE_W-1:0] phase_q;
    int                 bit_cnt;
    logic [CODE_W-1:0]  code_q;
    rsp_t               decoded_q [$];

    initial begin
        pending  = 0;
        failures = 0;
    end

    function automatic logic between(logic [TIME_W-1:0] t, logic [TIME_W-1:0] lo,
                                     logic [TIME_W-1:0] hi);
        return (t > lo) && (t < hi);
    endfunction

    // Advance the frame state by one word and return the result it causes.
    function automatic rsp_t decode_word(req_t w);
        rsp_t             r;
        logic [KEY_W-1:0] key;
        r = '0;
        if (w.req_type == REQ_TIMEOUT) begin
            phase_q = PH_IDLE;
        end
        else begin
            case (phase_q)
                PH_LEADER_MARK:
                    if (between(w.elapsed_us, win[REG_LEADER_MARK_MIN], win[REG_LEADER_MARK_MAX]))
                    begin
                        phase_q = PH_LEADER_SPACE;
                    end
                    else
                    begin
                        phase_q = PH_IDLE;
                        r.frame_error = 1'b1;
                    end
                PH_LEADER_SPACE:
                    if (between(w.elapsed_us, win[REG_LEADER_SPACE_MIN],
                                win[REG_LEADER_SPACE_MAX]))
                    begin
                        phase_q = PH_BIT_MARK;
                    end
                    else
                    begin
                        phase_q = PH_IDLE;
                        r.frame_error = 1'b1;
                    end
                PH_BIT_MARK:
                    if (between(w.elapsed_us, win[REG_PULSE_MIN], win[REG_BIT_MARK_MAX]))
                    begin
                        phase_q = PH_BIT_SPACE;
                    end
                    else
                    begin
                        phase_q = PH_IDLE;
                        r.frame_error = 1'b1;
                    end
                PH_BIT_SPACE:
                    if (between(w.elapsed_us, win[REG_PULSE_MIN], win[REG_BIT_SPACE_MAX]))
                    begin
                        code_q  = {code_q[CODE_W-2:0], w.elapsed_us > win[REG_ONE_THRESHOLD]};
                        bit_cnt = bit_cnt + 1;
                        if (bit_cnt >= CODE_W)
                        begin
                            r.code_valid = 1'b1;
                            r.code       = code_q;
                            key          = code_q[15:8];
                            // last match wins
                            for (int i = 0; i < KEY_TABLE_LEN; i++)
                            begin
                                if (KEY_TABLE[i] == key)
                                begin
                                    r.key_found = 1'b1;
                                    r.key_index = i[KEY_IDX_W-1:0];
                                end
                            end
                            phase_q = PH_IDLE;
                        end
                        else
                        begin
                            phase_q = PH_BIT_MARK;
                        end
                    end
                    else
                    begin
                        phase_q = PH_IDLE;
                        r.frame_error = 1'b1;
                    end
                default:
                begin
                    // any edge in idle opens a frame
                    bit_cnt = 0;
                    code_q  = '0;
                    phase_q = PH_LEADER_MARK;
                end
            endcase
        end
        r.phase         = phase_q;
        r.expect_rising = (phase_q == PH_LEADER_MARK) || (phase_q == PH_BIT_MARK);
        return r;
    endfunction

    function automatic void check_field(string name, logic [CODE_W-1:0] want,
                                        logic [CODE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            win[REG_LEADER_MARK_MIN]  = RST_LEADER_MARK_MIN;
            win[REG_LEADER_MARK_MAX]  = RST_LEADER_MARK_MAX;
            win[REG_LEADER_SPACE_MIN] = RST_LEADER_SPACE_MIN;
            win[REG_LEADER_SPACE_MAX] = RST_LEADER_SPACE_MAX;
            win[REG_PULSE_MIN]        = RST_PULSE_MIN;
            win[REG_BIT_MARK_MAX]     = RST_BIT_MARK_MAX;
            win[REG_BIT_SPACE_MAX]    = RST_BIT_SPACE_MAX;
            win[REG_ONE_THRESHOLD]    = RST_ONE_THRESHOLD;
            phase_q = PH_IDLE;
            bit_cnt = 0;
            code_q  = '0;
            decoded_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                win[cfg_index] = cfg_data;

            if (rsp_valid && !rsp_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result word with no request outstanding: 0x%0h", rsp);
                    failures++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("phase", CODE_W'(want.phase), CODE_W'(rsp.phase));
                    check_field("expect_rising", CODE_W'(want.expect_rising),
                                CODE_W'(rsp.expect_rising));
                    check_field("frame_error", CODE_W'(want.frame_error),
                                CODE_W'(rsp.frame_error));
                    check_field("code_valid", CODE_W'(want.code_valid),
                                CODE_W'(rsp.code_valid));
                    check_field("code", want.code, rsp.code);
                    check_field("key_found", CODE_W'(want.key_found),
                                CODE_W'(rsp.key_found));
                    check_field("key_index", CODE_W'(want.key_index),
                                CODE_W'(rsp.key_index));
                end
            end

            if (req_valid && !req_stall)
                decoded_q.push_back(decode_word(req));

            pending <= decoded_q.size();
        end
    end

endmodule

// File: bench/nec_ir_pulse_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_unit_test: top-level bench for the NEC IR decoder
// Drives edge and timeout words: boundary cases first, then well-formed frames
// with random codes, broken frames and noise, across several window settings.
// A side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nir_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    int pending;
    int failures;
    int cycles     = 0;
    int burst_left = 0;
    int gap_max    = 0;
    int stall_mode = 0;
    int stall_left = 0;

    // window settings as last written, used to shape frames
    int win [CFG_COUNT];

    always #5 clk = ~clk;

    nec_ir_pulse_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nec_ir_frame_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    // Receiver back-pressure: switch at random among four stall patterns.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 256);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_left % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL nec_ir_pulse_decoder_unit");
            $finish;
        end
    end

    function automatic req_t mk(logic kind, int t);
        req_t w;
        w.req_type   = kind;
        w.elapsed_us = t[TIME_W-1:0];
        return w;
    endfunction

    // Time strictly inside (lo, hi), leaning on the edges; anything if empty.
    function automatic int pick_inside(int lo, int hi);
        if (hi - lo < 2)
            return $urandom_range(0, 65535);
        case ($urandom_range(0, 9))
            0:       return lo + 1;
            1:       return hi - 1;
            default: return $urandom_range(lo + 1, hi - 1);
        endcase
    endfunction

    function automatic int space_for_bit(logic b);
        int thr;
        thr = win[REG_ONE_THRESHOLD];
        if (b)
            return pick_inside((thr > win[REG_PULSE_MIN]) ? thr : win[REG_PULSE_MIN],
                               win[REG_BIT_SPACE_MAX]);
        return pick_inside(win[REG_PULSE_MIN],
                           (thr + 1 < win[REG_BIT_SPACE_MAX]) ? thr + 1 : win[REG_BIT_SPACE_MAX]);
    endfunction

    function automatic req_t broken_word();
        case ($urandom_range(0, 3))
            0:       return mk(REQ_TIMEOUT, $urandom_range(0, 65535));
            1:       return mk(REQ_EDGE, 0);
            2:       return mk(REQ_EDGE, 65535);
            default: return mk(REQ_EDGE, $urandom_range(0, 65535));
        endcase
    endfunction

    // Present one word; bursts of random length with random gaps in between.
    task automatic send_word(req_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= w;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic send_noise(int n);
        repeat (n) send_word(mk($urandom_range(0, 3) == 0, $urandom_range(0, 65535)));
    endtask

    // One frame with a random code, sometimes broken at a random word.
    task automatic send_frame();
        req_t              words [$];
        logic [CODE_W-1:0] code;
        int                spot;
        code = $urandom();
        if ($urandom_range(0, 9) < 7)
            code[15:8] = KEY_TABLE[$urandom_range(0, KEY_TABLE_LEN - 1)];
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        words.push_back(mk(REQ_EDGE, $urandom_range(0, 65535)));
        words.push_back(mk(REQ_EDGE, pick_inside(win[REG_LEADER_MARK_MIN],
                                                 win[REG_LEADER_MARK_MAX])));
        words.push_back(mk(REQ_EDGE, pick_inside(win[REG_LEADER_SPACE_MIN],
                                                 win[REG_LEADER_SPACE_MAX])));
        for (int i = CODE_W - 1; i >= 0; i--)
        begin
            words.push_back(mk(REQ_EDGE, pick_inside(win[REG_PULSE_MIN],
                                                     win[REG_BIT_MARK_MAX])));
            words.push_back(mk(REQ_EDGE, space_for_bit(code[i])));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            spot        = $urandom_range(1, words.size() - 1);
            words[spot] = broken_word();
        end
        foreach (words[i])
            send_word(words[i]);
    endtask

    // Hold off until every result is back and the pipeline has drained.
    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_windows(int lm_min, int lm_max, int ls_min, int ls_max,
                                int p_min, int bm_max, int bs_max, int thr);
        int vals [CFG_COUNT];
        vals = '{lm_min, lm_max, ls_min, ls_max, p_min, bm_max, bs_max, thr};
        settle();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i][TIME_W-1:0];
            do @(posedge clk); while (!cfg_ready);
            win[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        win = '{RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX, RST_LEADER_SPACE_MIN,
                RST_LEADER_SPACE_MAX, RST_PULSE_MIN, RST_BIT_MARK_MAX,
                RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boundaries of the timing windows at reset settings
        send_word(mk(REQ_TIMEOUT, 16'hffff));
        send_word(mk(REQ_EDGE, 16'hffff));
        send_word(mk(REQ_EDGE, 8500));
        send_word(mk(REQ_EDGE, 0));
        send_word(mk(REQ_EDGE, 9500));
        send_word(mk(REQ_EDGE, 0));
        send_word(mk(REQ_EDGE, 8501));
        send_word(mk(REQ_EDGE, 4000));
        send_word(mk(REQ_EDGE, 0));
        send_word(mk(REQ_EDGE, 9499));
        send_word(mk(REQ_EDGE, 4999));
        send_word(mk(REQ_TIMEOUT, 0));
        send_word(mk(REQ_EDGE, 1234));
        send_word(mk(REQ_EDGE, 9000));
        send_word(mk(REQ_EDGE, 4500));
        send_word(mk(REQ_EDGE, 400));
        send_word(mk(REQ_EDGE, 0));
        send_word(mk(REQ_EDGE, 9000));
        send_word(mk(REQ_EDGE, 4001));
        send_word(mk(REQ_EDGE, 699));
        send_word(mk(REQ_EDGE, 1800));
        send_word(mk(REQ_EDGE, 0));
        send_word(mk(REQ_EDGE, 9000));
        send_word(mk(REQ_EDGE, 4500));
        send_word(mk(REQ_EDGE, 700));

        repeat (5)
        begin
            send_frame();
            send_noise($urandom_range(2, 10));
        end

        load_windows(8000, 10000, 3500, 5500, 300, 800, 2000, 1100);
        repeat (4)
        begin
            send_frame();
            send_noise($urandom_range(2, 10));
        end

        // empty windows: every edge past idle fails
        load_windows(0, 0, 0, 0, 0, 0, 0, 0);
        send_noise(30);

        load_windows(0, 65535, 0, 65535, 0, 65535, 65535, $urandom_range(1, 65534));
        repeat (3) send_frame();

        load_windows(0, 65535, 0, 65535, 0, 65535, 65535, 65535);
        send_frame();
        load_windows(0, 65535, 0, 65535, 0, 65535, 65535, 0);
        send_frame();

        // inverted windows
        load_windows(65535, 0, 65535, 0, 65535, 0, 0, 32768);
        send_noise(20);

        load_windows(RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX, RST_LEADER_SPACE_MIN,
                     RST_LEADER_SPACE_MAX, RST_PULSE_MIN, RST_BIT_MARK_MAX,
                     RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD);
        repeat (2)
        begin
            send_frame();
            send_noise($urandom_range(2, 10));
        end

        settle();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("PASS nec_ir_pulse_decoder_unit");
        else
            $display("FAIL nec_ir_pulse_decoder_unit");
        $finish;
    end

endmodule

// File: sim.f
hdl/nir_pkg.sv
hdl/nir_key_lookup.sv
hdl/nec_ir_pulse_decoder_unit.sv
bench/nec_ir_frame_checker.sv
bench/nec_ir_pulse_decoder_unit_test.sv
